### rtl/core/decimal_seven_segment_formatter_unit_macros.svh
// assertion macros shared by the formatter rtl
`ifndef DECIMAL_SEVEN_SEGMENT_FORMATTER_UNIT_MACROS_SVH
`define DECIMAL_SEVEN_SEGMENT_FORMATTER_UNIT_MACROS_SVH

// condition in the same cycle
`define DSSF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition in the following cycle
`define DSSF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/dssf_pkg.sv
// package: constants, side-band type and digit helpers for the decimal formatter
package dssf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int VALUE_W   = 32;
    localparam int PLACES_W  = 3;
    localparam int SEG_W     = 8;
    localparam int POW_W     = 10;
    localparam int NUM_W     = 14;
    localparam int DISP_MAX  = 9999;

    localparam logic [SEG_W-1:0] MINUS_SEG = 8'h40;
    localparam logic [SEG_W-1:0] POINT_SEG = 8'h80;
    localparam logic [SEG_W-1:0] BLANK_SEG = 8'h00;

    typedef struct packed {
        logic       neg;
        logic [1:0] p;
        logic       sat;
    } t_side;

    function automatic logic [6:0] seg_font(input logic [3:0] d);
        logic [6:0] s;
        case (d)
            4'd0:    s = 7'h3F;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5B;
            4'd3:    s = 7'h4F;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6D;
            4'd6:    s = 7'h7D;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7F;
            4'd9:    s = 7'h6F;
            default: s = 7'h00;
        endcase
        return s;
    endfunction

    function automatic logic [POW_W-1:0] pow10(input logic [1:0] p);
        logic [POW_W-1:0] r;
        case (p)
            2'd0:    r = 10'd1;
            2'd1:    r = 10'd10;
            2'd2:    r = 10'd100;
            default: r = 10'd1000;
        endcase
        return r;
    endfunction

    // one decimal digit of x at weight unit, x below ten times unit
    function automatic logic [3:0] digit_of(input logic [NUM_W-1:0] x,
                                            input logic [NUM_W-1:0] unit);
        logic [3:0] d;
        d = '0;
        for (int k = 1; k <= 9; k++) begin
            if (x >= NUM_W'(k * int'(unit))) begin
                d = 4'(k);
            end
        end
        return d;
    endfunction

endpackage

### rtl/core/decimal_seven_segment_formatter_unit.sv
// top level: pipelined fixed-point to four-digit seven-segment formatter
//
//  channel | valid   | ready   | payload
//  --------+---------+---------+------------------------------------------------
//  in      | i_valid | o_ready | i_value (s32 fixed point), i_places (u3)
//  out     | o_valid | i_ready | o_seg_left, o_seg_mid_left, o_seg_mid_right,
//          |         |         | o_seg_right (u8 each), o_saturated (u1)
//
// one item per cycle sustained while i_ready is high, o_valid rises when the item reaches the last stage
// the seven register stages: negate, multiply, round and saturate, then the thousands,
// hundreds, and tens and units digits, then segment encoding
// each stage moves when it is empty or the stage after it moves, so bubbles close up
// a stall on i_ready holds every full stage with no empty stage after it; nothing is dropped or taken twice
// i_rst_n (synchronous, active low) empties the pipeline; data registers are not reset

`include "decimal_seven_segment_formatter_unit_macros.svh"

module decimal_seven_segment_formatter_unit #(
    parameter int FRAC_BITS = dssf_pkg::FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [dssf_pkg::VALUE_W-1:0] i_value,
    input  logic [dssf_pkg::PLACES_W-1:0]       i_places,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [dssf_pkg::SEG_W-1:0]          o_seg_left,
    output logic [dssf_pkg::SEG_W-1:0]          o_seg_mid_left,
    output logic [dssf_pkg::SEG_W-1:0]          o_seg_mid_right,
    output logic [dssf_pkg::SEG_W-1:0]          o_seg_right,
    output logic                                o_saturated
);

    localparam int NSTG   = 7;
    localparam int VW     = dssf_pkg::VALUE_W;
    localparam int NW     = dssf_pkg::NUM_W;
    localparam int SW     = dssf_pkg::SEG_W;
    localparam int PROD_W = VW + dssf_pkg::POW_W;
    localparam int SCL_W  = PROD_W + 1 - FRAC_BITS;
    localparam logic [PROD_W:0] HALF = (PROD_W + 1)'(1) << (FRAC_BITS - 1);

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_en;

    // stage registers
    logic [VW-1:0]     r_mag;
    logic [PROD_W-1:0] r_prod;
    logic [NW-1:0]     r_num;
    logic [3:0]        r_th3, r_th4, r_th5;
    logic [9:0]        r_rem3;
    logic [3:0]        r_hu4, r_hu5;
    logic [6:0]        r_rem4;
    logic [3:0]        r_te5, r_un5;
    dssf_pkg::t_side   r_side [0:NSTG-2];
    logic [SW-1:0]     r_seg [0:3];
    logic              r_sat;

    // next values
    logic [VW-1:0]     n_mag;
    logic [1:0]        n_p;
    logic [PROD_W:0]   w_rsum;
    logic [SCL_W-1:0]  w_scaled;
    logic              n_sat;
    logic [NW-1:0]     n_num;
    logic [3:0]        n_th, n_hu, n_te;
    logic [NW-1:0]     w_rem3x, w_rem4x, w_rem5x;
    logic [SW-1:0]     n_seg [0:3];
    logic [3:0]        w_dig [0:3];
    logic [1:0]        w_units;
    logic [1:0]        w_first;
    logic [3:0]        w_dp;

    // handshake chain, last stage first
    always_comb begin
        w_en[NSTG-1] = !r_vld[NSTG-1] || i_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 0: magnitude and clamped places
    assign n_mag = i_value[VW-1] ? VW'(-$unsigned(i_value)) : $unsigned(i_value);
    assign n_p   = i_places[2] ? 2'd3 : i_places[1:0];

    // stage 2: round half up, drop the fraction, saturate
    assign w_rsum   = {1'b0, r_prod} + HALF;
    assign w_scaled = SCL_W'(w_rsum >> FRAC_BITS);
    assign n_sat    = w_scaled > SCL_W'(dssf_pkg::DISP_MAX);
    assign n_num    = n_sat ? NW'(dssf_pkg::DISP_MAX) : w_scaled[NW-1:0];

    // stages 3 to 5: one decimal digit each, stage 5 also keeps the units remainder
    assign n_th    = dssf_pkg::digit_of(r_num, NW'(1000));
    assign w_rem3x = r_num - NW'(n_th * NW'(1000));
    assign n_hu    = dssf_pkg::digit_of(NW'(r_rem3), NW'(100));
    assign w_rem4x = NW'(r_rem3) - NW'(n_hu * NW'(100));
    assign n_te    = dssf_pkg::digit_of(NW'(r_rem4), NW'(10));
    assign w_rem5x = NW'(r_rem4) - NW'(n_te * NW'(10));

    // stage 6: blanking, sign and point
    always_comb begin
        w_dig[0] = r_th5;
        w_dig[1] = r_hu5;
        w_dig[2] = r_te5;
        w_dig[3] = r_un5;
        w_units  = 2'd3 - r_side[5].p;
        if (w_units > 2'd0 && w_dig[0] != 4'd0) begin
            w_first = 2'd0;
        end else if (w_units > 2'd1 && w_dig[1] != 4'd0) begin
            w_first = 2'd1;
        end else if (w_units > 2'd2 && w_dig[2] != 4'd0) begin
            w_first = 2'd2;
        end else begin
            w_first = w_units;
        end
        for (int i = 0; i < 4; i++) begin
            if (2'(i) < w_first) begin
                n_seg[i] = (r_side[5].neg && (3'(i) + 3'd1 == {1'b0, w_first}))
                         ? dssf_pkg::MINUS_SEG : dssf_pkg::BLANK_SEG;
            end else begin
                n_seg[i] = {1'b0, dssf_pkg::seg_font(w_dig[i])};
                if (2'(i) == w_units && r_side[5].p != 2'd0) begin
                    n_seg[i] = n_seg[i] | dssf_pkg::POINT_SEG;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_mag     <= n_mag;
            r_side[0] <= {i_value[VW-1], n_p, 1'b0};
        end
        if (w_en[1]) begin
            r_prod    <= PROD_W'(r_mag) * PROD_W'(dssf_pkg::pow10(r_side[0].p));
            r_side[1] <= r_side[0];
        end
        if (w_en[2]) begin
            r_num     <= n_num;
            r_side[2] <= {r_side[1].neg, r_side[1].p, n_sat};
        end
        if (w_en[3]) begin
            r_th3     <= n_th;
            r_rem3    <= w_rem3x[9:0];
            r_side[3] <= r_side[2];
        end
        if (w_en[4]) begin
            r_th4     <= r_th3;
            r_hu4     <= n_hu;
            r_rem4    <= w_rem4x[6:0];
            r_side[4] <= r_side[3];
        end
        if (w_en[5]) begin
            r_th5     <= r_th4;
            r_hu5     <= r_hu4;
            r_te5     <= n_te;
            r_un5     <= w_rem5x[3:0];
            r_side[5] <= r_side[4];
        end
        if (w_en[6]) begin
            for (int i = 0; i < 4; i++) begin
                r_seg[i] <= n_seg[i];
            end
            r_sat <= r_side[5].sat;
        end
    end

    assign o_seg_left      = r_seg[0];
    assign o_seg_mid_left  = r_seg[1];
    assign o_seg_mid_right = r_seg[2];
    assign o_seg_right     = r_seg[3];
    assign o_saturated     = r_sat;

    assign w_dp = {o_seg_left[7], o_seg_mid_left[7], o_seg_mid_right[7], o_seg_right[7]};

    `DSSF_ASSERT_NOW(a_units_shown, i_clk, i_rst_n, o_valid, o_seg_right[6:0] != 7'h00,
        "rightmost digit blanked")
    `DSSF_ASSERT_NOW(a_one_point, i_clk, i_rst_n, o_valid, $onehot0(w_dp),
        "more than one decimal point lit")
    `DSSF_ASSERT_NOW(a_sat_nines, i_clk, i_rst_n, o_valid && o_saturated,
        o_seg_right[6:0] == dssf_pkg::seg_font(4'd9), "saturated item does not end in nine")
    `DSSF_ASSERT_NEXT(a_mid_hold, i_clk, i_rst_n, r_vld[3] && !w_en[3], r_vld[3],
        "stalled item lost in digit stage")

endmodule
